/* src/lpm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lpm_pkg;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_SUBJECT = 2'd1,
        OP_END     = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_ANY_ONE = 2'd1,
        KIND_ANY_RUN = 2'd2
    } t_kind;

    localparam logic [7:0] CH_ONE = 8'h5F;
    localparam logic [7:0] CH_RUN = 8'h25;
    localparam logic [7:0] CH_ESC = 8'h5C;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] byte_value;
        logic       new_pattern;
    } t_in_item;

    typedef struct packed {
        logic matched;
        logic status;
    } t_out_item;

endpackage

`default_nettype wire

/* src/lpm_run_close.sv */
`timescale 1ns / 1ps
`default_nettype none

module lpm_run_close #(
    parameter int WIDTH = 33
) (
    input  wire logic [WIDTH-1:0] i_gen,
    input  wire logic [WIDTH-1:0] i_prop,
    output logic      [WIDTH-1:0] o_out
);

    localparam int LEVELS = $clog2(WIDTH);

    logic [WIDTH-1:0] g [LEVELS+1];
    logic [WIDTH-1:0] p [LEVELS+1];

    // parallel prefix: out[j] set if some active bit i <= j has runs over i..j-1
    always_comb begin
        g[0] = i_gen;
        p[0] = i_prop;
        for (int k = 0; k < LEVELS; k++) begin
            for (int j = 0; j < WIDTH; j++) begin
                if (j >= (1 << k)) begin
                    g[k+1][j] = g[k][j] | (p[k][j] & g[k][j-(1<<k)]);
                    p[k+1][j] = p[k][j] & p[k][j-(1<<k)];
                end else begin
                    g[k+1][j] = g[k][j];
                    p[k+1][j] = p[k][j];
                end
            end
        end
        o_out = g[LEVELS];
    end

endmodule

`default_nettype wire

/* src/like_pattern_matcher.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  | valid       | ready       | payload
// ---------+-------------+-------------+------------------------------
// input    | i_in_valid  | o_in_ready  | i_in_item  (operation, byte, new)
// result   | o_out_valid | i_out_ready | o_out_item (matched, status)
//
// one transaction per cycle unless stalled; an item is registered, then applied to the
// pattern table and active-position vector once it advances
// an end transaction registers its result in r_out when it advances
// reset clears pattern length, flags and position vector; the table needs none
// a waiting result stalls only an end transaction; o_in_ready then follows i_out_ready

module like_pattern_matcher #(
    parameter int PATTERN_MAX = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire lpm_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output lpm_pkg::t_out_item      o_out_item
);

    import lpm_pkg::*;

    localparam int N  = PATTERN_MAX;
    localparam int IW = $clog2(N);
    localparam int LW = $clog2(N + 1);

    logic          r_in_valid;
    t_in_item      r_in;
    logic          r_out_valid;
    t_out_item     r_out;

    t_kind         r_kind [N];
    logic [7:0]    r_byte [N];
    logic [LW-1:0] r_len;
    logic          r_esc;
    logic          r_ovf;
    logic [N:0]    r_active;
    logic [N:0]    r_start;
    logic          r_subject_open;

    logic [LW-1:0] n_len;
    logic          n_esc;
    logic          n_ovf;
    logic [N:0]    n_active;
    logic [N:0]    n_start;
    logic          n_subject_open;
    logic          n_out_valid;
    t_out_item     n_out;

    logic          w_advance;
    logic [N-1:0]  w_run;
    logic [N-1:0]  w_step;
    logic [N:0]    w_base;
    logic [N:0]    w_consumed;
    logic [N:0]    w_prop;
    logic [N:0]    w_closed;
    logic [LW-1:0] w_len_eff;
    logic [LW-1:0] w_len_inc;
    logic          w_esc_eff;
    logic [N:0]    w_start_eff;
    logic          w_add;
    t_kind         w_add_kind;
    logic [7:0]    w_add_byte;
    logic          w_wr_en;

    assign w_advance = r_in_valid
                     && (r_in.operation != OP_END || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // per-position lanes
    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_run[i]  = (LW'(i) < r_len) && (r_kind[i] == KIND_ANY_RUN);
            w_step[i] = (LW'(i) < r_len) && (r_kind[i] != KIND_ANY_RUN)
                      && (r_kind[i] == KIND_ANY_ONE || r_byte[i] == r_in.byte_value);
        end
    end

    assign w_base = r_subject_open ? r_active : r_start;

    always_comb begin
        w_consumed = '0;
        for (int i = 0; i < N; i++) begin
            if (w_base[i] && w_run[i]) begin
                w_consumed[i] = 1'b1;
            end
            if (w_base[i] && w_step[i]) begin
                w_consumed[i+1] = 1'b1;
            end
        end
    end

    assign w_prop = {w_run, 1'b0};

    lpm_run_close #(
        .WIDTH (N + 1)
    ) u_run_close (
        .i_gen  (w_consumed),
        .i_prop (w_prop),
        .o_out  (w_closed)
    );

    // pattern compile
    always_comb begin
        w_len_eff   = r_in.new_pattern ? '0 : r_len;
        w_esc_eff   = r_in.new_pattern ? 1'b0 : r_esc;
        w_start_eff = r_in.new_pattern ? (N+1)'(1) : r_start;
        w_len_inc   = w_len_eff + 1'b1;
        w_add       = 1'b1;
        w_add_kind  = KIND_LITERAL;
        w_add_byte  = r_in.byte_value;
        n_esc       = 1'b0;
        priority if (w_esc_eff) begin
            w_add_kind = KIND_LITERAL;
        end else if (r_in.byte_value == CH_ESC) begin
            w_add = 1'b0;
            n_esc = 1'b1;
        end else if (r_in.byte_value == CH_ONE) begin
            w_add_kind = KIND_ANY_ONE;
            w_add_byte = 8'd0;
        end else if (r_in.byte_value == CH_RUN) begin
            w_add_kind = KIND_ANY_RUN;
            w_add_byte = 8'd0;
        end else begin
            w_add_kind = KIND_LITERAL;
        end
    end

    always_comb begin
        n_len          = r_len;
        n_ovf          = r_ovf;
        n_active       = r_active;
        n_start        = r_start;
        n_subject_open = r_subject_open;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out          = r_out;
        w_wr_en        = 1'b0;
        if (w_advance) begin
            unique case (r_in.operation)
                OP_LOAD: begin
                    n_subject_open = 1'b0;
                    n_len          = w_len_eff;
                    n_ovf          = r_in.new_pattern ? 1'b0 : r_ovf;
                    n_start        = w_start_eff;
                    if (w_add) begin
                        if (w_len_eff >= LW'(N)) begin
                            n_ovf = 1'b1;
                        end else begin
                            w_wr_en            = 1'b1;
                            n_len              = w_len_inc;
                            n_start[w_len_inc] = w_start_eff[w_len_eff]
                                               && (w_add_kind == KIND_ANY_RUN);
                        end
                    end
                end
                OP_SUBJECT: begin
                    n_subject_open = 1'b1;
                    n_active       = w_closed;
                end
                OP_END: begin
                    n_subject_open = 1'b0;
                    n_out_valid    = 1'b1;
                    n_out.matched  = w_base[r_len] && !r_ovf && !r_esc;
                    n_out.status   = r_ovf;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_len          <= '0;
            r_esc          <= 1'b0;
            r_ovf          <= 1'b0;
            r_active       <= '0;
            r_start        <= (N+1)'(1);
            r_subject_open <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_out_valid    <= n_out_valid;
            r_len          <= n_len;
            if (w_advance && r_in.operation == OP_LOAD) begin
                r_esc <= n_esc;
            end
            r_ovf          <= n_ovf;
            r_active       <= n_active;
            r_start        <= n_start;
            r_subject_open <= n_subject_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        r_out <= n_out;
        if (w_wr_en) begin
            r_kind[w_len_eff[IW-1:0]] <= w_add_kind;
            r_byte[w_len_eff[IW-1:0]] <= w_add_byte;
        end
    end

    a_status_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status |-> !o_out_item.matched)
        else $error("overflowed pattern reported a match");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(N))
        else $error("pattern length beyond table size");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_len == LW'(N))
        else $error("overflow flagged with room in table");

    a_load_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in.operation == OP_LOAD |=> !r_subject_open)
        else $error("subject still open after pattern load");

    a_active_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_subject_open |-> ((r_active >> r_len) >> 1) == '0)
        else $error("active position beyond pattern end");

endmodule

`default_nettype wire
